// ----- rtl/ohcs_pkg.sv -----
package ohcs_pkg;

  localparam int unsigned MAX_PARTICLES = 4096;
  localparam int unsigned ADDR_W        = $clog2(MAX_PARTICLES);
  localparam int unsigned VAL_W         = 56;
  localparam int unsigned NUM_W         = VAL_W + 24;
  localparam int unsigned STEP_W        = $clog2(NUM_W + 1);
  localparam int unsigned FACT_W        = 17;

  localparam logic [VAL_W-1:0]  HIT_CAP = VAL_W'(64'hFFFF_FFFF);
  localparam logic [FACT_W-1:0] ONE_Q16 = FACT_W'(65536);

  typedef enum logic [1:0] {
    REQ_PIXEL  = 2'd0,
    REQ_RADIUS = 2'd1,
    REQ_COLOR  = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

endpackage

// ----- rtl/occlusion_hit_count_and_shade_top.sv -----
// Occlusion hit counter and shader.
// Input stream (s_axis_*): one transaction per request, kind in tuser. Pixel
// words bump a per-particle hit count, radius requests normalise a count by
// radius squared and track the maximum, colour requests return a shaded
// colour on the output stream (m_axis_*), clear requests zero the store.
// Config channel (cfg_*): shade intensity in Q1.16, always ready; write only
// while idle.
// Requests are served one at a time by a read-modify-write on the 4096 x 56 hit
// memory (separate read and write addresses) and a shared radix-2 serial divider;
// skipped pixels write nothing, zero radii and trivial colour ratios bypass the
// divider.
// The divider takes 80 steps for a radius, 16 for a colour ratio.
// Results sit in an output register; a new request is taken while it waits.
// A colour request finishing while the register is still full waits there.
// Reset: a clearing pass sweeps all 4096 memory entries, no input
// transaction is taken meanwhile; intensity returns to 0.5.
module occlusion_hit_count_and_shade_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pixel_word, particle_index, radius_fixed, red_in, green_in, blue_in, zero pad
  input  logic [87:0] s_axis_tdata,
  // req_type
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_index, red_out, green_out, blue_out, shade_factor, zero pad
  output logic [55:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [16:0] cfg_data_i
);

  localparam int unsigned AW = ohcs_pkg::ADDR_W;
  localparam int unsigned VW = ohcs_pkg::VAL_W;
  localparam int unsigned NW = ohcs_pkg::NUM_W;
  localparam int unsigned SW = ohcs_pkg::STEP_W;
  localparam int unsigned FW = ohcs_pkg::FACT_W;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_EXEC, S_DIV, S_FIN} state_e;

  state_e            state_q;
  ohcs_pkg::req_e    kind_q;
  logic [AW-1:0]     addr_q, clr_q;
  logic [15:0]       rad_q;
  logic [23:0]       rgb_q;
  logic [VW-1:0]     max_q, rd_q;
  logic [FW-1:0]     inten_q, ratio_q;
  logic [VW-1:0]     rem_q, div_q, quo_q;
  logic [NW-1:0]     num_q;
  logic              ovf_q;
  logic [SW-1:0]     step_q;
  logic              out_valid_q;
  logic [55:0]       out_q;

  logic [VW-1:0]     mem [ohcs_pkg::MAX_PARTICLES];

  logic              accept;
  logic [31:0]       in_word, slot;
  logic [AW-1:0]     in_idx, rd_addr;
  ohcs_pkg::req_e    in_kind;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [VW-1:0]     wdata;
  logic [VW:0]       rem_sh;
  logic              ge;
  logic [VW-1:0]     rem_n, quo_n, rad_val;
  logic [FW-1:0]     inten_c;
  logic [FW:0]       fsum;
  logic [FW-1:0]     factor;
  logic [24:0]       pr, pg, pb;
  logic              out_load;

  assign in_word  = s_axis_tdata[31:0];
  assign in_idx   = s_axis_tdata[32 +: AW];
  assign in_kind  = ohcs_pkg::req_e'(s_axis_tuser);
  assign slot     = in_word - 32'd1;
  assign rd_addr  = (in_kind == ohcs_pkg::REQ_PIXEL) ? slot[AW-1:0] : in_idx;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;

  assign rem_sh = {rem_q, num_q[NW-1]};
  assign ge     = rem_sh >= {1'b0, div_q};
  assign rem_n  = ge ? VW'(rem_sh - {1'b0, div_q}) : rem_sh[VW-1:0];
  assign quo_n  = {quo_q[VW-2:0], ge};
  assign rad_val = ovf_q ? {VW{1'b1}} : quo_q;

  assign inten_c = (inten_q > ohcs_pkg::ONE_Q16) ? ohcs_pkg::ONE_Q16 : inten_q;
  assign fsum    = {1'b0, ohcs_pkg::ONE_Q16} - {1'b0, inten_c} + {1'b0, ratio_q};
  assign factor  = (fsum > {1'b0, ohcs_pkg::ONE_Q16}) ? ohcs_pkg::ONE_Q16 : fsum[FW-1:0];
  assign pr = rgb_q[7:0]   * factor;
  assign pg = rgb_q[15:8]  * factor;
  assign pb = rgb_q[23:16] * factor;
  assign out_load = (state_q == S_FIN) && (kind_q == ohcs_pkg::REQ_COLOR)
                    && (!out_valid_q || m_axis_tready);

  always_comb begin
    we    = 1'b0;
    waddr = addr_q;
    wdata = rad_val;
    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
      end
      S_EXEC: begin
        if (kind_q == ohcs_pkg::REQ_PIXEL) begin
          we    = rd_q < ohcs_pkg::HIT_CAP;
          wdata = rd_q + VW'(1);
        end else if (kind_q == ohcs_pkg::REQ_RADIUS && rad_q == '0) begin
          we    = 1'b1;
          wdata = (rd_q[VW-1:VW-8] != '0) ? {VW{1'b1}} : {rd_q[VW-9:0], 8'd0};
        end
      end
      S_FIN: we = (kind_q == ohcs_pkg::REQ_RADIUS);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      max_q       <= '0;
      inten_q     <= FW'(32768);
      out_valid_q <= 1'b0;
      kind_q      <= ohcs_pkg::REQ_PIXEL;
      step_q      <= '0;
      ovf_q       <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        inten_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_q <= {3'd0, factor, pb[23:16], pg[23:16], pr[23:16], addr_q};
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(ohcs_pkg::MAX_PARTICLES - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            kind_q <= in_kind;
            addr_q <= rd_addr;
            rad_q  <= s_axis_tdata[59:44];
            rgb_q  <= s_axis_tdata[83:60];
            if (in_kind == ohcs_pkg::REQ_CLEAR) begin
              clr_q   <= '0;
              max_q   <= '0;
              state_q <= S_CLEAR;
            end else if (in_kind != ohcs_pkg::REQ_PIXEL ||
                         (in_word != '0 && slot < ohcs_pkg::MAX_PARTICLES)) begin
              state_q <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          ovf_q <= 1'b0;
          quo_q <= '0;
          case (kind_q)
            ohcs_pkg::REQ_RADIUS: begin
              if (rad_q == '0) begin
                if (wdata > max_q) max_q <= wdata;
                state_q <= S_IDLE;
              end else begin
                div_q   <= VW'({16'd0, rad_q} * {16'd0, rad_q});
                num_q   <= {rd_q, 24'd0};
                rem_q   <= '0;
                step_q  <= SW'(NW);
                state_q <= S_DIV;
              end
            end
            ohcs_pkg::REQ_COLOR: begin
              if (max_q == '0) begin
                ratio_q <= '0;
                state_q <= S_FIN;
              end else if (rd_q >= max_q) begin
                ratio_q <= ohcs_pkg::ONE_Q16;
                state_q <= S_FIN;
              end else begin
                div_q   <= max_q;
                num_q   <= '0;
                rem_q   <= rd_q;
                step_q  <= SW'(16);
                state_q <= S_DIV;
              end
            end
            default: state_q <= S_IDLE;
          endcase
        end
        S_DIV: begin
          rem_q  <= rem_n;
          num_q  <= {num_q[NW-2:0], 1'b0};
          quo_q  <= quo_n;
          ovf_q  <= ovf_q | quo_q[VW-1];
          step_q <= step_q - SW'(1);
          if (step_q == SW'(1)) begin
            ratio_q <= {1'b0, quo_n[15:0]};
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (kind_q == ohcs_pkg::REQ_RADIUS) begin
            if (rad_val > max_q) max_q <= rad_val;
            state_q <= S_IDLE;
          end else if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

// ----- rtl/ohcs_checker.sv -----
module ohcs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  a_factor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[52:36] <= 17'd65536 && m_axis_tdata[55:53] == 3'd0)
    else $error("shade factor out of range");

  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser != ohcs_pkg::REQ_PIXEL
    |=> !s_axis_tready)
    else $error("ready while request in progress");

  a_reset_clear: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !s_axis_tready)
    else $error("ready during clearing pass");

endmodule

bind occlusion_hit_count_and_shade_top ohcs_checker u_ohcs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

// ----- verif/occlusion_hit_count_and_shade_top_tb.sv -----
`timescale 1ns / 100ps

module occlusion_hit_count_and_shade_top_tb;

  localparam int unsigned WDOG_LIMIT = 30000;
  localparam int unsigned QUIET_CYC  = 4300;
  localparam int unsigned HOLD_CYC   = 400;
  localparam logic [55:0] VMASK      = {56{1'b1}};

  // lowest field last, matching the output tdata layout
  typedef struct packed {
    logic [16:0] factor;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [11:0] idx;
  } shade_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [16:0] cfg_data_i = '0;

  logic [55:0] hit_count [ohcs_pkg::MAX_PARTICLES];
  logic [55:0] peak_val;
  logic [16:0] intensity;
  shade_t      shade_q[$];

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  logic        hold_start = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cyc = 0;
  int unsigned n_items = 0;
  int unsigned n_shades = 0;
  int unsigned n_mismatch = 0;
  int unsigned n_fail = 0;

  occlusion_hit_count_and_shade_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [87:0] pack_req(logic [31:0] word, logic [11:0] idx,
                                           logic [15:0] rad, logic [7:0] r,
                                           logic [7:0] g, logic [7:0] b);
    return {4'b0, b, g, r, rad, idx, word};
  endfunction

  function automatic logic [55:0] normalise(logic [55:0] v, logic [15:0] rad);
    logic [79:0] q;
    if (rad == 0) begin
      return (v > (VMASK >> 8)) ? VMASK : (v << 8);
    end
    q = ({24'b0, v} << 24) / (80'(rad) * 80'(rad));
    return (q > 80'(VMASK)) ? VMASK : q[55:0];
  endfunction

  // updates the hit store and queues the shaded colour for colour requests
  task automatic update_shading(ohcs_pkg::req_e kind, logic [87:0] d);
    logic [31:0] word;
    logic [11:0] idx;
    logic [55:0] v;
    logic [71:0] num;
    logic [16:0] ratio, inten, f;
    logic [17:0] fsum;
    shade_t      s;
    word = d[31:0];
    idx  = d[43:32];
    case (kind)
      ohcs_pkg::REQ_PIXEL: begin
        if (word != 0 && (word - 1) < ohcs_pkg::MAX_PARTICLES &&
            hit_count[word - 1] < 56'hFFFF_FFFF)
          hit_count[word - 1] = hit_count[word - 1] + 1;
      end
      ohcs_pkg::REQ_RADIUS: begin
        v = normalise(hit_count[idx], d[59:44]);
        hit_count[idx] = v;
        if (v > peak_val) peak_val = v;
      end
      ohcs_pkg::REQ_COLOR: begin
        v = hit_count[idx];
        if (peak_val == 0) ratio = 0;
        else if (v >= peak_val) ratio = ohcs_pkg::ONE_Q16;
        else begin
          num = {v, 16'b0} / {16'b0, peak_val};
          ratio = num[16:0];
        end
        inten = (intensity > ohcs_pkg::ONE_Q16) ? ohcs_pkg::ONE_Q16 : intensity;
        fsum = 18'(ohcs_pkg::ONE_Q16) - 18'(inten) + 18'(ratio);
        f = (fsum > 18'(ohcs_pkg::ONE_Q16)) ? ohcs_pkg::ONE_Q16 : fsum[16:0];
        s.idx    = idx;
        s.red    = 8'((25'(d[67:60]) * 25'(f)) >> 16);
        s.green  = 8'((25'(d[75:68]) * 25'(f)) >> 16);
        s.blue   = 8'((25'(d[83:76]) * 25'(f)) >> 16);
        s.factor = f;
        shade_q.push_back(s);
      end
      default: begin
        foreach (hit_count[i]) hit_count[i] = '0;
        peak_val = '0;
      end
    endcase
  endtask

  task automatic send_req(ohcs_pkg::req_e kind, logic [87:0] d);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    update_shading(kind, d);
    n_items++;
  endtask

  task automatic send_pixel(logic [31:0] word);
    send_req(ohcs_pkg::REQ_PIXEL, pack_req(word, 12'($urandom), 16'($urandom),
                                           8'($urandom), 8'($urandom), 8'($urandom)));
  endtask

  task automatic send_radius(logic [11:0] idx, logic [15:0] rad);
    send_req(ohcs_pkg::REQ_RADIUS, pack_req($urandom, idx, rad, 8'($urandom),
                                            8'($urandom), 8'($urandom)));
  endtask

  task automatic send_color(logic [11:0] idx, logic [7:0] r, logic [7:0] g,
                            logic [7:0] b);
    send_req(ohcs_pkg::REQ_COLOR, pack_req($urandom, idx, 16'($urandom), r, g, b));
  endtask

  task automatic wait_idle;
    s_axis_tvalid <= 1'b0;
    while (shade_q.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYC) @(posedge clk_i);
  endtask

  task automatic write_intensity(logic [16:0] val);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    intensity = val;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_directed;
    send_color(12'd0, 8'd255, 8'd255, 8'd255);
    send_pixel(32'd0);
    send_pixel(32'd1);
    send_pixel(32'd1);
    send_pixel(32'd4096);
    send_pixel(32'd4097);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h8000_0000);
    send_color(12'd0, 8'd255, 8'd0, 8'd128);
    send_radius(12'd0, 16'd0);
    send_radius(12'd0, 16'd1);
    send_radius(12'd4095, 16'hFFFF);
    send_radius(12'd4095, 16'd0);
    send_pixel(32'd2);
    send_radius(12'd1, 16'h0100);
    send_color(12'd0, 8'd255, 8'd255, 8'd255);
    send_color(12'd1, 8'd1, 8'd2, 8'd3);
    send_color(12'd4095, 8'd0, 8'd0, 8'd0);
    send_color(12'd2, 8'd200, 8'd100, 8'd50);
    send_req(ohcs_pkg::REQ_CLEAR,
             pack_req(32'hFFFF_FFFF, 12'hFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
    send_color(12'd0, 8'd255, 8'd255, 8'd255);
    wait_idle();
  endtask

  // bursts of hits on up to eight neighbouring particles, then radii and colours, now and then a clear
  task automatic test_random(int unsigned n, int unsigned src_pct, int unsigned snk_pct,
                             bit with_hold);
    logic [11:0] base;
    int unsigned span, sent, k;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    sent = 0;
    while (sent < n) begin
      base = 12'($urandom);
      span = $urandom_range(8, 1);
      if (with_hold && sent > n / 2) begin
        s_axis_tvalid <= 1'b0;
        hold_start <= 1'b1;
        @(posedge clk_i);
        hold_start <= 1'b0;
        with_hold = 1'b0;
      end
      repeat ($urandom_range(24, 4)) begin
        k = $urandom_range(9);
        if (k == 0) send_pixel($urandom);
        else if (k == 1) send_pixel(32'd0);
        else send_pixel(32'(base) + 32'($urandom_range(span - 1)) + 1);
        sent++;
      end
      for (int i = 0; i < span; i++) begin
        k = $urandom_range(9);
        send_radius(base + 12'(i), k == 0 ? 16'd0 :
                    k == 1 ? 16'($urandom) : 16'($urandom_range(64, 1)));
        sent++;
      end
      repeat ($urandom_range(2 * span, 1)) begin
        send_color($urandom_range(3) == 0 ? 12'($urandom) :
                   base + 12'($urandom_range(span - 1)),
                   8'($urandom), 8'($urandom), 8'($urandom));
        sent++;
      end
      if ($urandom_range(99) < 2) begin
        send_req(ohcs_pkg::REQ_CLEAR,
                 pack_req($urandom, 12'($urandom), 16'($urandom),
                          8'($urandom), 8'($urandom), 8'($urandom)));
        sent++;
      end
    end
    wait_idle();
  endtask

  always @(posedge clk_i) begin
    if (hold_start) hold_left <= HOLD_CYC;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk_i) begin
    shade_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[52:0];
      n_shades++;
      if (shade_q.size() == 0) begin
        n_fail++;
        $display("unexpected shade transaction %h", got);
      end else begin
        want = shade_q.pop_front();
        if (got !== want || m_axis_tdata[55:53] !== 3'b0) begin
          n_mismatch++;
          n_fail++;
          if (n_mismatch <= 10)
            $display({"mismatch: exp idx=%0d rgb=%0d/%0d/%0d f=%0d,",
                      " got idx=%0d rgb=%0d/%0d/%0d f=%0d"},
                     want.idx, want.red, want.green, want.blue, want.factor,
                     got.idx, got.red, got.green, got.blue, got.factor);
        end
      end
    end
    m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cyc <= 0;
    else
      quiet_cyc <= quiet_cyc + 1;
    if (quiet_cyc >= WDOG_LIMIT) begin
      $display("[occlusion_hit_count_and_shade_top] ERROR");
      $finish;
    end
  end

  initial begin
    foreach (hit_count[i]) hit_count[i] = '0;
    peak_val  = '0;
    intensity = 17'd32768;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    write_intensity(17'd0);
    test_random(610, 8, 80, 1'b0);
    write_intensity(17'd65536);
    test_random(610, 80, 8, 1'b1);
    write_intensity(17'h1FFFF);
    test_random(300, 0, 0, 1'b0);
    write_intensity(17'($urandom_range(65536)));
    test_random(300, 0, 0, 1'b1);
    n_fail += shade_q.size();
    $display("covered %0d requests, %0d shaded colours, intensities 0.5, 0, 1, above 1, random",
             n_items, n_shades);
    if (n_fail == 0)
      $display("[occlusion_hit_count_and_shade_top] OK");
    else
      $display("[occlusion_hit_count_and_shade_top] ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ohcs_pkg.sv
rtl/occlusion_hit_count_and_shade_top.sv
rtl/ohcs_checker.sv
verif/occlusion_hit_count_and_shade_top_tb.sv
